@@ rtl/ipv4_icmp_ingress_validator_top_assert.svh @@
// Assertion macros shared by the validator front and FIFO modules.
// Each macro expects i_clk and i_rst_n in the enclosing module.
`ifndef IPV4_ICMP_INGRESS_VALIDATOR_TOP_ASSERT_SVH
`define IPV4_ICMP_INGRESS_VALIDATOR_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");
`define ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");
`else
`define ASSERT_IMPL(name, ante, cons)
`define ASSERT_NEXT(name, ante, cons)
`endif

`endif

@@ rtl/ipicv_pkg.sv @@
`default_nettype none

package ipicv_pkg;

    localparam int LINK_HEADER_BYTES_DEF = 14;
    localparam int MAX_FRAME_BYTES_DEF   = 65536;

    localparam int POS_W      = 17;
    localparam int FIFO_DEPTH = 4;

    // IP and ICMP header offsets within the datagram
    localparam logic [POS_W-1:0] OFF_VER_IHL  = 17'd0;
    localparam logic [POS_W-1:0] OFF_TLEN_HI  = 17'd2;
    localparam logic [POS_W-1:0] OFF_TLEN_LO  = 17'd3;
    localparam logic [POS_W-1:0] OFF_FLAG_HI  = 17'd6;
    localparam logic [POS_W-1:0] OFF_FLAG_LO  = 17'd7;
    localparam logic [POS_W-1:0] OFF_TTL      = 17'd8;
    localparam logic [POS_W-1:0] OFF_PROTO    = 17'd9;
    localparam logic [POS_W-1:0] OFF_HCS_HI   = 17'd10;
    localparam logic [POS_W-1:0] OFF_HCS_LO   = 17'd11;
    localparam logic [POS_W-1:0] IP_HDR_BYTES = 17'd20;
    localparam logic [POS_W-1:0] OFF_TC_HI    = 17'd20;
    localparam logic [POS_W-1:0] OFF_TC_LO    = 17'd21;
    localparam logic [POS_W-1:0] OFF_ICS_HI   = 17'd22;
    localparam logic [POS_W-1:0] OFF_ICS_LO   = 17'd23;

    localparam logic [7:0]  PROTO_ICMP    = 8'd1;
    localparam logic [7:0]  PROTO_TCP     = 8'd6;
    localparam logic [15:0] IP_RF         = 16'h8000;
    localparam logic [3:0]  IP_VERSION_4  = 4'd4;
    localparam logic [3:0]  IHL_MIN       = 4'd5;
    localparam logic [7:0]  ICMP_ECHO_REP = 8'd0;
    localparam logic [7:0]  ICMP_ECHO_REQ = 8'd8;

    localparam logic [3:0] V_ICMP_OK   = 4'd0;
    localparam logic [3:0] V_TCP_PASS  = 4'd1;
    localparam logic [3:0] V_BAD_PROTO = 4'd2;
    localparam logic [3:0] V_TTL       = 4'd3;
    localparam logic [3:0] V_EVIL      = 4'd4;
    localparam logic [3:0] V_IP_CSUM   = 4'd5;
    localparam logic [3:0] V_TRUNC     = 4'd6;
    localparam logic [3:0] V_VERSION   = 4'd7;
    localparam logic [3:0] V_IHL       = 4'd8;
    localparam logic [3:0] V_ICMP_TYPE = 4'd9;
    localparam logic [3:0] V_ICMP_CODE = 4'd10;
    localparam logic [3:0] V_ICMP_CSUM = 4'd11;

    // Everything the verdict needs, captured at the last byte of a frame
    typedef struct packed {
        logic [POS_W-1:0] ip_bytes;
        logic [15:0]      total_length;
        logic [7:0]       version_and_ihl;
        logic [15:0]      flags_and_offset;
        logic [7:0]       time_to_live;
        logic [7:0]       protocol_number;
        logic [16:0]      header_sum;
        logic [15:0]      stored_header_checksum;
        logic [15:0]      icmp_type_code;
        logic [16:0]      payload_sum;
        logic [15:0]      stored_icmp_checksum;
    } t_frame_rec;

    // Ones' complement add with end-around carry
    function automatic logic [16:0] oc_add(input logic [16:0] s, input logic [15:0] w);
        logic [17:0] t;
        t = {1'b0, s} + {2'b00, w};
        if (t > 18'h0FFFF) begin
            return {1'b0, t[15:0]} + 17'd1;
        end
        return t[16:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/ipicv_front.sv @@
`default_nettype none
`include "ipv4_icmp_ingress_validator_top_assert.svh"

module ipicv_front #(
    parameter int LINK_HEADER_BYTES = ipicv_pkg::LINK_HEADER_BYTES_DEF,
    parameter int MAX_FRAME_BYTES   = ipicv_pkg::MAX_FRAME_BYTES_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    input  wire logic [7:0]           i_s_tdata,   // [7:0] data_byte
    input  wire logic                 i_s_tlast,
    input  wire logic                 i_full,
    output logic                      o_push,
    output ipicv_pkg::t_frame_rec     o_rec
);
    import ipicv_pkg::*;

    localparam logic [POS_W-1:0] LINK_LEN  = POS_W'(LINK_HEADER_BYTES);
    localparam logic [POS_W-1:0] POS_LIMIT =
        (MAX_FRAME_BYTES < 'h1FFFF) ? POS_W'(MAX_FRAME_BYTES) : 17'h1FFFF;

    logic [POS_W-1:0] r_pos, n_pos;
    logic [16:0]      r_hsum, n_hsum;
    logic [16:0]      r_psum, n_psum;
    logic [7:0]       r_pend, n_pend;
    logic [7:0]       r_ver, n_ver;
    logic [15:0]      r_tlen, n_tlen;
    logic [15:0]      r_flags, n_flags;
    logic [7:0]       r_ttl, n_ttl;
    logic [7:0]       r_proto, n_proto;
    logic [15:0]      r_hcs, n_hcs;
    logic [15:0]      r_tc, n_tc;
    logic [15:0]      r_ics, n_ics;

    logic             accept;
    logic [POS_W-1:0] ofs;
    logic [7:0]       val;

    assign o_s_tready = !i_full;
    assign accept     = i_s_tvalid && o_s_tready;
    assign ofs        = r_pos - LINK_LEN;

    always_comb begin
        n_pos   = r_pos;
        n_hsum  = r_hsum;
        n_psum  = r_psum;
        n_pend  = r_pend;
        n_ver   = r_ver;
        n_tlen  = r_tlen;
        n_flags = r_flags;
        n_ttl   = r_ttl;
        n_proto = r_proto;
        n_hcs   = r_hcs;
        n_tc    = r_tc;
        n_ics   = r_ics;
        val     = i_s_tdata;
        if (accept && (r_pos < POS_LIMIT)) begin
            n_pos = r_pos + 17'd1;
            if (r_pos >= LINK_LEN) begin
                case (ofs)
                    OFF_VER_IHL:              n_ver   = i_s_tdata;
                    OFF_TLEN_HI, OFF_TLEN_LO: n_tlen  = {r_tlen[7:0], i_s_tdata};
                    OFF_FLAG_HI, OFF_FLAG_LO: n_flags = {r_flags[7:0], i_s_tdata};
                    OFF_TTL:                  n_ttl   = i_s_tdata;
                    OFF_PROTO:                n_proto = i_s_tdata;
                    OFF_HCS_HI, OFF_HCS_LO:   n_hcs   = {r_hcs[7:0], i_s_tdata};
                    OFF_TC_HI, OFF_TC_LO:     n_tc    = {r_tc[7:0], i_s_tdata};
                    OFF_ICS_HI, OFF_ICS_LO:   n_ics   = {r_ics[7:0], i_s_tdata};
                    default: ;
                endcase
                if (ofs < IP_HDR_BYTES) begin
                    // checksum field counts as zero
                    if (ofs == OFF_HCS_HI || ofs == OFF_HCS_LO) val = 8'h00;
                    if (!ofs[0]) n_pend = val;
                    else         n_hsum = oc_add(r_hsum, {r_pend, val});
                end else if (ofs < {1'b0, r_tlen}) begin
                    if (ofs == OFF_ICS_HI || ofs == OFF_ICS_LO) val = 8'h00;
                    if (!ofs[0]) begin
                        // odd length: pad the final byte with a zero low byte
                        if (POS_W'(ofs + 17'd1) == {1'b0, r_tlen}) begin
                            n_psum = oc_add(r_psum, {val, 8'h00});
                        end else begin
                            n_pend = val;
                        end
                    end else begin
                        n_psum = oc_add(r_psum, {r_pend, val});
                    end
                end
            end
        end
    end

    always_comb begin
        o_push                       = accept && i_s_tlast;
        o_rec.ip_bytes               = (n_pos >= LINK_LEN) ? n_pos - LINK_LEN : '0;
        o_rec.total_length           = n_tlen;
        o_rec.version_and_ihl        = n_ver;
        o_rec.flags_and_offset       = n_flags;
        o_rec.time_to_live           = n_ttl;
        o_rec.protocol_number        = n_proto;
        o_rec.header_sum             = n_hsum;
        o_rec.stored_header_checksum = n_hcs;
        o_rec.icmp_type_code         = n_tc;
        o_rec.payload_sum            = n_psum;
        o_rec.stored_icmp_checksum   = n_ics;
    end

    always_ff @(posedge i_clk) begin
        // clear all frame state on reset and after the last byte
        if (!i_rst_n || (accept && i_s_tlast)) begin
            r_pos   <= '0;
            r_hsum  <= '0;
            r_psum  <= '0;
            r_pend  <= '0;
            r_ver   <= '0;
            r_tlen  <= '0;
            r_flags <= '0;
            r_ttl   <= '0;
            r_proto <= '0;
            r_hcs   <= '0;
            r_tc    <= '0;
            r_ics   <= '0;
        end else begin
            r_pos   <= n_pos;
            r_hsum  <= n_hsum;
            r_psum  <= n_psum;
            r_pend  <= n_pend;
            r_ver   <= n_ver;
            r_tlen  <= n_tlen;
            r_flags <= n_flags;
            r_ttl   <= n_ttl;
            r_proto <= n_proto;
            r_hcs   <= n_hcs;
            r_tc    <= n_tc;
            r_ics   <= n_ics;
        end
    end

    `ASSERT_NEXT(a_clear_after_last, accept && i_s_tlast, r_pos == '0 && r_tlen == '0)
    `ASSERT_IMPL(a_pos_bounded, 1'b1, r_pos <= POS_LIMIT)
    `ASSERT_IMPL(a_sums_folded, 1'b1, r_hsum <= 17'h10000 && r_psum <= 17'h10000)

endmodule

`default_nettype wire

@@ rtl/ipicv_fifo.sv @@
`default_nettype none
`include "ipv4_icmp_ingress_validator_top_assert.svh"

module ipicv_fifo (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    input  wire ipicv_pkg::t_frame_rec i_data,
    output logic                       o_full,
    input  wire logic                  i_pop,
    output ipicv_pkg::t_frame_rec      o_data,
    output logic                       o_empty
);
    import ipicv_pkg::*;

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(FIFO_DEPTH);

    t_frame_rec        r_slot [FIFO_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    assign o_full  = (r_count == DEPTH_CNT);
    assign o_empty = (r_count == '0);
    assign o_data  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `ASSERT_IMPL(a_no_overflow, i_push, !o_full)
    `ASSERT_IMPL(a_no_underflow, i_pop, !o_empty)
    `ASSERT_NEXT(a_count_up, i_push && !i_pop, r_count == $past(r_count) + 1'b1)
    `ASSERT_IMPL(a_ptr_gap, 1'b1, r_count <= DEPTH_CNT)

endmodule

`default_nettype wire

@@ rtl/ipicv_back.sv @@
`default_nettype none

module ipicv_back (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_empty,
    input  wire ipicv_pkg::t_frame_rec i_rec,
    output logic                       o_pop,
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    output logic [7:0]                 o_m_tdata    // [3:0] verdict, [7:4] zero
);
    import ipicv_pkg::*;

    logic       r_valid;
    logic [3:0] r_verdict, n_verdict;
    logic [7:0] rec_type, rec_code;

    assign o_pop      = !i_empty && (!r_valid || i_m_tready);
    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {4'b0000, r_verdict};
    assign rec_type   = i_rec.icmp_type_code[15:8];
    assign rec_code   = i_rec.icmp_type_code[7:0];

    // first failing test decides
    always_comb begin
        if (i_rec.ip_bytes < IP_HDR_BYTES) begin
            n_verdict = V_TRUNC;
        end else if (i_rec.protocol_number != PROTO_ICMP
                     && i_rec.protocol_number != PROTO_TCP) begin
            n_verdict = V_BAD_PROTO;
        end else if (i_rec.time_to_live == 8'h00) begin
            n_verdict = V_TTL;
        end else if (i_rec.flags_and_offset == IP_RF) begin
            n_verdict = V_EVIL;
        end else if (~i_rec.header_sum[15:0] != i_rec.stored_header_checksum) begin
            n_verdict = V_IP_CSUM;
        end else if (i_rec.ip_bytes < {1'b0, i_rec.total_length}) begin
            n_verdict = V_TRUNC;
        end else if (i_rec.version_and_ihl[7:4] != IP_VERSION_4) begin
            n_verdict = V_VERSION;
        end else if (i_rec.version_and_ihl[3:0] < IHL_MIN) begin
            n_verdict = V_IHL;
        end else if (i_rec.protocol_number == PROTO_TCP) begin
            n_verdict = V_TCP_PASS;
        end else if (rec_type != ICMP_ECHO_REP && rec_type != ICMP_ECHO_REQ) begin
            n_verdict = V_ICMP_TYPE;
        end else if (rec_code != 8'h00) begin
            n_verdict = V_ICMP_CODE;
        end else if (~i_rec.payload_sum[15:0] != i_rec.stored_icmp_checksum) begin
            n_verdict = V_ICMP_CSUM;
        end else begin
            n_verdict = V_ICMP_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_verdict <= n_verdict;
        end
    end

endmodule

`default_nettype wire

@@ rtl/ipv4_icmp_ingress_validator_top.sv @@
// Channel   Dir  Handshake              Payload
// s_*       in   i_s_tvalid/o_s_tready  i_s_tdata[7:0] frame byte, i_s_tlast end of frame
// m_*       out  o_m_tvalid/i_m_tready  o_m_tdata[3:0] verdict, one word per frame
//
// One input byte per cycle unless the queue is full; the parser updates sums per byte.
// A verdict shows on o_m_tvalid once the frame's last byte is taken and has passed
// the queue write, then the output register; it waits longer only while the output is stalled.
// The front keeps taking bytes during an output stall until the four-entry
// frame queue fills; then o_s_tready drops.
// i_rst_n is synchronous, active low, and clears all frame state at once.
`default_nettype none

module ipv4_icmp_ingress_validator_top #(
    parameter int LINK_HEADER_BYTES = ipicv_pkg::LINK_HEADER_BYTES_DEF,
    parameter int MAX_FRAME_BYTES   = ipicv_pkg::MAX_FRAME_BYTES_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    output logic            o_s_tready,
    input  wire logic [7:0] i_s_tdata,   // [7:0] data_byte
    input  wire logic       i_s_tlast,   // last_byte
    output logic            o_m_tvalid,
    input  wire logic       i_m_tready,
    output logic [7:0]      o_m_tdata    // [3:0] verdict, [7:4] zero
);
    import ipicv_pkg::*;

    t_frame_rec push_rec, pop_rec;
    logic       push, pop, full, empty;

    ipicv_front #(
        .LINK_HEADER_BYTES (LINK_HEADER_BYTES),
        .MAX_FRAME_BYTES   (MAX_FRAME_BYTES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .i_full     (full),
        .o_push     (push),
        .o_rec      (push_rec)
    );

    ipicv_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_rec),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (pop_rec),
        .o_empty (empty)
    );

    ipicv_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (empty),
        .i_rec      (pop_rec),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

`default_nettype wire

@@ tb/ipv4_icmp_ingress_validator_top_test.sv @@
`timescale 1ns / 100ps

module ipv4_icmp_ingress_validator_top_test;

    import ipicv_pkg::*;

    localparam int LINK_BYTES  = LINK_HEADER_BYTES_DEF;
    localparam int POS_CAP     = (MAX_FRAME_BYTES_DEF < 'h1FFFF) ? MAX_FRAME_BYTES_DEF : 'h1FFFF;
    localparam int STALL_LIMIT = 4000;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_frame_byte;

    typedef logic [7:0] t_octets[];

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_s_tvalid = 1'b0;
    logic [7:0] i_s_tdata  = 8'h00;   // [7:0] data_byte
    logic       i_s_tlast  = 1'b0;
    logic       i_m_tready = 1'b0;
    logic       o_s_tready;
    logic       o_m_tvalid;
    logic [7:0] o_m_tdata;            // [3:0] verdict, [7:4] zero

    ipv4_icmp_ingress_validator_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #1 i_clk = ~i_clk;

    t_frame_byte byte_q[$];
    logic [3:0]  pending_verdicts[$];

    int send_idle_pct   = 16;
    int recv_idle_pct   = 53;
    int bytes_queued    = 0;
    int bytes_accepted  = 0;
    int frames_accepted = 0;
    int verdicts_seen   = 0;
    int fail_count      = 0;
    int stall_cycles    = 0;
    int verdict_tally[16];

    // Frame parser state, mirrors what the block keeps per frame
    logic [16:0] pos_cnt   = '0;
    logic [16:0] hdr_sum   = '0;
    logic [16:0] pay_sum   = '0;
    logic [7:0]  hi_byte   = '0;
    logic [7:0]  ver_ihl   = '0;
    logic [15:0] tot_len   = '0;
    logic [15:0] frag_word = '0;
    logic [7:0]  ttl_v     = '0;
    logic [7:0]  proto_v   = '0;
    logic [15:0] hdr_csum  = '0;
    logic [15:0] type_code = '0;
    logic [15:0] icmp_csum = '0;

    function automatic logic [16:0] end_around_add(input logic [16:0] acc, input logic [15:0] w);
        logic [17:0] t;
        t = acc + w;
        if (t > 18'h0FFFF) t = {2'b00, t[15:0]} + 18'd1;
        return t[16:0];
    endfunction

    function automatic logic [3:0] frame_verdict();
        logic [16:0] ip_n;
        ip_n = (pos_cnt >= LINK_BYTES) ? 17'(pos_cnt - LINK_BYTES) : '0;
        if (ip_n < IP_HDR_BYTES) return V_TRUNC;
        if (proto_v != PROTO_ICMP && proto_v != PROTO_TCP) return V_BAD_PROTO;
        if (ttl_v == 8'd0) return V_TTL;
        if (frag_word == IP_RF) return V_EVIL;
        if (~hdr_sum[15:0] != hdr_csum) return V_IP_CSUM;
        if (ip_n < tot_len) return V_TRUNC;
        if (ver_ihl[7:4] != IP_VERSION_4) return V_VERSION;
        if (ver_ihl[3:0] < IHL_MIN) return V_IHL;
        if (proto_v == PROTO_TCP) return V_TCP_PASS;
        if (type_code[15:8] != ICMP_ECHO_REP && type_code[15:8] != ICMP_ECHO_REQ)
            return V_ICMP_TYPE;
        if (type_code[7:0] != 8'd0) return V_ICMP_CODE;
        if (~pay_sum[15:0] != icmp_csum) return V_ICMP_CSUM;
        return V_ICMP_OK;
    endfunction

    task automatic clear_frame_state();
        pos_cnt   = '0;
        hdr_sum   = '0;
        pay_sum   = '0;
        hi_byte   = '0;
        ver_ihl   = '0;
        tot_len   = '0;
        frag_word = '0;
        ttl_v     = '0;
        proto_v   = '0;
        hdr_csum  = '0;
        type_code = '0;
        icmp_csum = '0;
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic last);
        logic [16:0] off;
        logic [7:0]  val;
        logic [3:0]  v;
        if (pos_cnt < POS_CAP) begin
            if (pos_cnt >= LINK_BYTES) begin
                off = 17'(pos_cnt - LINK_BYTES);
                case (off)
                    OFF_VER_IHL: ver_ihl = b;
                    OFF_TLEN_HI, OFF_TLEN_LO: tot_len = {tot_len[7:0], b};
                    OFF_FLAG_HI, OFF_FLAG_LO: frag_word = {frag_word[7:0], b};
                    OFF_TTL: ttl_v = b;
                    OFF_PROTO: proto_v = b;
                    OFF_HCS_HI, OFF_HCS_LO: hdr_csum = {hdr_csum[7:0], b};
                    OFF_TC_HI, OFF_TC_LO: type_code = {type_code[7:0], b};
                    OFF_ICS_HI, OFF_ICS_LO: icmp_csum = {icmp_csum[7:0], b};
                    default: ;
                endcase
                if (off < IP_HDR_BYTES) begin
                    val = (off == OFF_HCS_HI || off == OFF_HCS_LO) ? 8'h00 : b;
                    if (!off[0]) hi_byte = val;
                    else hdr_sum = end_around_add(hdr_sum, {hi_byte, val});
                end else if (off < tot_len) begin
                    val = (off == OFF_ICS_HI || off == OFF_ICS_LO) ? 8'h00 : b;
                    if (!off[0]) begin
                        // odd tail: pad the low byte with zero
                        if (off + 1 == tot_len) pay_sum = end_around_add(pay_sum, {val, 8'h00});
                        else hi_byte = val;
                    end else begin
                        pay_sum = end_around_add(pay_sum, {hi_byte, val});
                    end
                end
            end
            pos_cnt = pos_cnt + 17'd1;
        end
        if (last) begin
            v = frame_verdict();
            pending_verdicts.push_back(v);
            verdict_tally[v]++;
            frames_accepted++;
            clear_frame_state();
        end
    endtask

    function automatic logic [15:0] fold_words(input t_octets pkt, input int from, input int upto);
        logic [31:0] acc;
        acc = '0;
        for (int k = from; k < upto; k += 2)
            acc += {pkt[k], ((k + 1 < upto) ? pkt[k + 1] : 8'h00)};
        while (acc[31:16] != 16'd0) acc = acc[15:0] + acc[31:16];
        return acc[15:0];
    endfunction

    task automatic push_byte(input logic [7:0] data, input logic last);
        t_frame_byte w;
        w.data = data;
        w.last = last;
        byte_q.push_back(w);
        bytes_queued++;
    endtask

    task automatic queue_raw(input int n);
        for (int k = 0; k < n; k++) push_byte(8'($urandom_range(255)), k == n - 1);
    endtask

    // Build a link header plus an IP datagram with correct sums, optionally
    // spoiled by the error masks; send ip_cap bytes of the datagram.
    task automatic queue_ip_frame(input logic [7:0] proto, input logic [7:0] ttl,
                                  input logic [7:0] vi, input logic [15:0] flags,
                                  input logic [15:0] tlen, input logic [7:0] msg_type,
                                  input logic [7:0] msg_code, input int ip_cap,
                                  input logic [15:0] hcs_err, input logic [15:0] ics_err);
        t_octets     pkt;
        int          n;
        logic [15:0] csum;
        n = ip_cap;
        if (n < tlen) n = int'(tlen);
        if (n < 24) n = 24;
        pkt = new[n];
        foreach (pkt[k]) pkt[k] = 8'($urandom_range(255));
        pkt[0]  = vi;
        pkt[2]  = tlen[15:8];
        pkt[3]  = tlen[7:0];
        pkt[6]  = flags[15:8];
        pkt[7]  = flags[7:0];
        pkt[8]  = ttl;
        pkt[9]  = proto;
        pkt[10] = 8'h00;
        pkt[11] = 8'h00;
        pkt[20] = msg_type;
        pkt[21] = msg_code;
        pkt[22] = 8'h00;
        pkt[23] = 8'h00;
        csum = ~fold_words(pkt, 0, 20) ^ hcs_err;
        pkt[10] = csum[15:8];
        pkt[11] = csum[7:0];
        csum = ~fold_words(pkt, 20, tlen) ^ ics_err;
        pkt[22] = csum[15:8];
        pkt[23] = csum[7:0];
        for (int k = 0; k < LINK_BYTES; k++)
            push_byte(8'($urandom_range(255)), ip_cap == 0 && k == LINK_BYTES - 1);
        for (int k = 0; k < ip_cap; k++) push_byte(pkt[k], k == ip_cap - 1);
    endtask

    task automatic queue_random_frame();
        logic [7:0]  proto, ttl, vi, ty, cd;
        logic [15:0] flags, tlen, herr, ierr;
        int          r, cap;
        r = $urandom_range(99);
        if (r < 20) begin
            queue_raw($urandom_range(1, 48));
            return;
        end
        r = $urandom_range(99);
        proto = (r < 60) ? PROTO_ICMP : ((r < 85) ? PROTO_TCP : 8'($urandom_range(255)));
        ttl = ($urandom_range(19) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
        flags = ($urandom_range(9) == 0) ? IP_RF : 16'($urandom_range(16'hFFFF));
        vi = ($urandom_range(99) < 85) ? {IP_VERSION_4, 4'($urandom_range(5, 15))}
                                       : 8'($urandom_range(255));
        r = $urandom_range(99);
        ty = (r < 45) ? ICMP_ECHO_REQ : ((r < 85) ? ICMP_ECHO_REP : 8'($urandom_range(255)));
        cd = ($urandom_range(99) < 88) ? 8'd0 : 8'($urandom_range(255));
        if ($urandom_range(99) < 8) begin
            tlen = 16'($urandom_range(0, 20));
            cap = 20 + $urandom_range(0, 6);
        end else begin
            tlen = 16'(20 + $urandom_range(0, 28));
            r = $urandom_range(99);
            if (r < 75) cap = tlen;
            else if (r < 85) cap = tlen + $urandom_range(1, 8);
            else if (r < 95) cap = $urandom_range(0, tlen);
            else cap = $urandom_range(0, tlen + 8);
        end
        herr = ($urandom_range(99) < 8) ? 16'($urandom_range(1, 16'hFFFF)) : 16'h0000;
        ierr = ($urandom_range(99) < 8) ? 16'($urandom_range(1, 16'hFFFF)) : 16'h0000;
        queue_ip_frame(proto, ttl, vi, flags, tlen, ty, cd, cap, herr, ierr);
    endtask

    task automatic run_random(input int n_bytes, input int n_frames);
        int start_bytes, frames;
        start_bytes = bytes_queued;
        frames = 0;
        while (bytes_queued - start_bytes < n_bytes || frames < n_frames) begin
            queue_random_frame();
            frames++;
        end
    endtask

    // Hold off new bytes until every verdict owed has been seen
    task automatic wait_drained();
        while (byte_q.size() != 0 || i_s_tvalid || pending_verdicts.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] exp,
                                   input logic [7:0] act);
        fail_count++;
        if (fail_count <= 10)
            $display("ERROR %0t: %s: expected %0d, got %0d", $time, what, exp, act);
    endtask

    always @(posedge i_clk) begin : drive_bytes
        t_frame_byte nxt;
        logic        slot_free;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            slot_free = !i_s_tvalid || o_s_tready;
            if (i_s_tvalid && o_s_tready) begin
                parse_byte(i_s_tdata, i_s_tlast);
                bytes_accepted++;
            end
            if (slot_free) begin
                if (byte_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = byte_q.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= nxt.data;
                    i_s_tlast  <= nxt.last;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : check_verdicts
        logic [3:0] want;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                verdicts_seen++;
                if (pending_verdicts.size() == 0) begin
                    report_mismatch("verdict word with no frame outstanding", 8'hxx, o_m_tdata);
                end else begin
                    want = pending_verdicts.pop_front();
                    if (o_m_tdata[3:0] !== want)
                        report_mismatch("verdict", {4'h0, want}, {4'h0, o_m_tdata[3:0]});
                    if (o_m_tdata[7:4] !== 4'h0)
                        report_mismatch("verdict pad bits", 8'h00, {4'h0, o_m_tdata[7:4]});
                end
            end
            i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("no progress for %0d cycles, %0d verdicts outstanding",
                     STALL_LIMIT, pending_verdicts.size());
            $display("status: fail");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // well-formed echo request (even ICMP length), echo reply (odd), TCP
        queue_ip_frame(PROTO_ICMP, 8'd64, 8'h45, 16'h4000, 16'd24, ICMP_ECHO_REQ, 8'd0, 24,
                       16'h0000, 16'h0000);
        queue_ip_frame(PROTO_ICMP, 8'd255, 8'h4F, 16'h0000, 16'd25, ICMP_ECHO_REP, 8'd0, 25,
                       16'h0000, 16'h0000);
        queue_ip_frame(PROTO_TCP, 8'd1, 8'h45, 16'hC000, 16'd20, 8'd3, 8'd7, 20,
                       16'h0000, 16'h0000);
        // unsupported protocols
        queue_ip_frame(8'd17, 8'd64, 8'h45, 16'h0000, 16'd20, ICMP_ECHO_REQ, 8'd0, 20,
                       16'h0000, 16'h0000);
        queue_ip_frame(8'd255, 8'd64, 8'h45, 16'h0000, 16'd20, ICMP_ECHO_REQ, 8'd0, 20,
                       16'h0000, 16'h0000);
        // expired TTL, evil bit alone, evil bit with other bits set
        queue_ip_frame(PROTO_ICMP, 8'd0, 8'h45, 16'h0000, 16'd20, ICMP_ECHO_REQ, 8'd0, 20,
                       16'h0000, 16'h0000);
        queue_ip_frame(PROTO_ICMP, 8'd64, 8'h45, IP_RF, 16'd20, ICMP_ECHO_REQ, 8'd0, 20,
                       16'h0000, 16'h0000);
        queue_ip_frame(PROTO_ICMP, 8'd64, 8'h45, 16'h8001, 16'd20, ICMP_ECHO_REQ, 8'd0, 20,
                       16'h0000, 16'h0000);
        // header checksum off by one bit and by all bits
        queue_ip_frame(PROTO_ICMP, 8'd64, 8'h45, 16'h0000, 16'd20, ICMP_ECHO_REQ, 8'd0, 20,
                       16'h0001, 16'h0000);
        queue_ip_frame(PROTO_TCP, 8'd64, 8'h45, 16'h0000, 16'd20, ICMP_ECHO_REQ, 8'd0, 20,
                       16'hFFFF, 16'h0000);
        // cut short of total length, cut inside the IP header, link header only, one byte
        queue_ip_frame(PROTO_ICMP, 8'd64, 8'h45, 16'h0000, 16'd24, ICMP_ECHO_REQ, 8'd0, 22,
                       16'h0000, 16'h0000);
        queue_ip_frame(PROTO_ICMP, 8'd64, 8'h45, 16'h0000, 16'd24, ICMP_ECHO_REQ, 8'd0, 19,
                       16'h0000, 16'h0000);
        queue_ip_frame(PROTO_ICMP, 8'd64, 8'h45, 16'h0000, 16'd24, ICMP_ECHO_REQ, 8'd0, 0,
                       16'h0000, 16'h0000);
        queue_raw(1);
        run_random(60, 1);
        wait_drained();

        send_idle_pct = 53;
        recv_idle_pct = 16;
        // version and header length
        queue_ip_frame(PROTO_ICMP, 8'd64, 8'h65, 16'h0000, 16'd20, ICMP_ECHO_REQ, 8'd0, 20,
                       16'h0000, 16'h0000);
        queue_ip_frame(PROTO_ICMP, 8'd64, 8'h44, 16'h0000, 16'd20, ICMP_ECHO_REQ, 8'd0, 20,
                       16'h0000, 16'h0000);
        // ICMP type, code and checksum
        queue_ip_frame(PROTO_ICMP, 8'd64, 8'h45, 16'h0000, 16'd24, 8'd3, 8'd0, 24,
                       16'h0000, 16'h0000);
        queue_ip_frame(PROTO_ICMP, 8'd64, 8'h45, 16'h0000, 16'd24, ICMP_ECHO_REQ, 8'd1, 24,
                       16'h0000, 16'h0000);
        queue_ip_frame(PROTO_ICMP, 8'd64, 8'h45, 16'h0000, 16'd24, ICMP_ECHO_REQ, 8'd0, 24,
                       16'h0000, 16'h8000);
        run_random(60, 1);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        // total length at or below the header, ICMP header not captured, trailing bytes
        queue_ip_frame(PROTO_ICMP, 8'd64, 8'h45, 16'h0000, 16'd20, ICMP_ECHO_REQ, 8'd0, 24,
                       16'h0000, 16'h0000);
        queue_ip_frame(PROTO_ICMP, 8'd64, 8'h45, 16'h0000, 16'd20, ICMP_ECHO_REQ, 8'd0, 20,
                       16'h0000, 16'h0000);
        queue_ip_frame(PROTO_ICMP, 8'd64, 8'h45, 16'h0000, 16'd0, ICMP_ECHO_REP, 8'd0, 24,
                       16'h0000, 16'h0000);
        queue_ip_frame(PROTO_ICMP, 8'd64, 8'h45, 16'h0000, 16'd24, ICMP_ECHO_REQ, 8'd0, 29,
                       16'h0000, 16'h0000);
        run_random(60, 1);
        wait_drained();
        repeat (8) @(negedge i_clk);

        $display("covered %0d bytes in %0d frames under three stall mixes, %0d verdicts",
                 bytes_accepted, frames_accepted, verdicts_seen);
        $write("verdict mix ok/tcp/proto/ttl/evil/ipcs: %0d %0d %0d %0d %0d %0d",
               verdict_tally[V_ICMP_OK], verdict_tally[V_TCP_PASS],
               verdict_tally[V_BAD_PROTO], verdict_tally[V_TTL], verdict_tally[V_EVIL],
               verdict_tally[V_IP_CSUM]);
        $display(", trunc/ver/ihl/type/code/icmpcs: %0d %0d %0d %0d %0d %0d",
                 verdict_tally[V_TRUNC], verdict_tally[V_VERSION], verdict_tally[V_IHL],
                 verdict_tally[V_ICMP_TYPE], verdict_tally[V_ICMP_CODE],
                 verdict_tally[V_ICMP_CSUM]);
        if (fail_count == 0 && pending_verdicts.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
